@@ src/crl_pkg.sv @@
// shared constants and register indexes for the combing residue limiter
package crl_pkg;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;
   localparam int COEF_BITS      = 16;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_AMOUNT        = 3'd0,
      CSR_STRENGTH      = 3'd1,
      CSR_SCALE         = 3'd2,
      CSR_EXTERNAL_MODE = 3'd3
   } csr_index_type;

   localparam logic [COEF_BITS-1:0] STRENGTH_RESET = 16'd11059;
   localparam logic [COEF_BITS-1:0] SCALE_RESET    = 16'd1024;

   localparam int NUM_STAGES = 6;

endpackage

@@ src/combing_residue_limiter.sv @@
// combing residue limiter: six-stage pixel pipeline with its control registers
//
// One pixel enters on the req_ channel (source, 3-tap blur, second reference)
// and one limited pixel leaves on the rsp_ channel, in order, one for one.
// A beat is taken at a rising edge where valid is high and stall is low.
// rsp_valid rises once the beat has moved through every stage register, and
// the block takes one beat per cycle with no stall. The six stages are:
// differences, gain multiply, magnitude select, scale multiply, truncate and
// add, clamp. When rsp_stall holds a result, each stage still loads as long
// as some stage ahead of it is empty, so bubbles are squeezed out and
// req_stall rises only once every stage holds a beat. Nothing is dropped or
// repeated.
// Registers are written through csr_write_enable / csr_index / csr_write_data;
// the user must write them only while the pipeline is empty, which the block
// does not enforce. Indexes past the list are ignored. Synchronous reset
// empties the pipeline and loads amount = full pixel range, strength = 2.7 and
// scale = 0.25 (unsigned fixed point, FRAC_BITS fraction bits), internal mode.
module combing_residue_limiter #(
   parameter int PIXEL_BITS = 8,
   parameter int FRAC_BITS  = 12
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [PIXEL_BITS-1:0]                req_source_pixel,
   input  logic [PIXEL_BITS-1:0]                req_small_blur,
   input  logic [PIXEL_BITS-1:0]                req_second_ref,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [PIXEL_BITS-1:0]                rsp_result_pixel,
   input  logic                                 csr_write_enable,
   input  logic [crl_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [crl_pkg::CSR_DATA_BITS-1:0]    csr_write_data
);

   localparam int NST = crl_pkg::NUM_STAGES;
   localparam int CB  = crl_pkg::COEF_BITS;
   localparam int DW  = PIXEL_BITS + 1;        // pixel difference
   localparam int TW  = PIXEL_BITS + 1 + CB;   // terms in fixed point
   localparam int PW  = TW + CB + 1;           // scaled product
   localparam int AW  = PW - 2 * FRAC_BITS;    // integer correction
   localparam int SW  = AW + 1;                // base plus correction
   localparam logic [PW-1:0] ROUND_BIAS = (PW'(1) << (2 * FRAC_BITS)) - PW'(1);
   localparam logic [PIXEL_BITS-1:0] PIX_MAX = {PIXEL_BITS{1'b1}};

   // control registers
   logic [PIXEL_BITS-1:0] amount_ff;
   logic [CB-1:0]         strength_ff;
   logic [CB-1:0]         scale_ff;
   logic                  external_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         amount_ff        <= PIX_MAX;
         strength_ff      <= crl_pkg::STRENGTH_RESET;
         scale_ff         <= crl_pkg::SCALE_RESET;
         external_mode_ff <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (crl_pkg::csr_index_type'(csr_index))
            crl_pkg::CSR_AMOUNT:        amount_ff        <= csr_write_data[PIXEL_BITS-1:0];
            crl_pkg::CSR_STRENGTH:      strength_ff      <= csr_write_data[CB-1:0];
            crl_pkg::CSR_SCALE:         scale_ff         <= csr_write_data[CB-1:0];
            crl_pkg::CSR_EXTERNAL_MODE: external_mode_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // pipeline flow: a stage loads when it is empty or the one ahead moves
   logic [NST-1:0] valid_ff;
   logic [NST-1:0] valid_in;
   logic [NST-1:0] load;

   always_comb begin
      load[NST-1] = !valid_ff[NST-1] || !rsp_stall;
      for (int k = NST - 2; k >= 0; k--) begin
         load[k] = !valid_ff[k] || load[k+1];
      end
      valid_in[0] = load[0] ? req_valid : valid_ff[0];
      for (int k = 1; k < NST; k++) begin
         valid_in[k] = load[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = !load[0];
   assign rsp_valid = valid_ff[NST-1];

   // stage 1: differences
   logic signed [DW-1:0]  s1_d1_ff, s1_d1_in;
   logic signed [DW-1:0]  s1_diff_ff, s1_diff_in;
   logic [PIXEL_BITS-1:0] s1_base_ff, s1_base_in;
   logic [PIXEL_BITS-1:0] s1_src_ff;
   logic                  s1_ext_ff;

   always_comb begin
      s1_d1_in = $signed({1'b0, req_source_pixel}) - $signed({1'b0, req_small_blur});
      if (external_mode_ff) begin
         s1_diff_in = $signed({1'b0, req_source_pixel}) - $signed({1'b0, req_second_ref});
         s1_base_in = req_second_ref;
      end else begin
         s1_diff_in = $signed({1'b0, req_small_blur}) - $signed({1'b0, req_second_ref});
         s1_base_in = req_small_blur;
      end
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         s1_d1_ff   <= s1_d1_in;
         s1_diff_ff <= s1_diff_in;
         s1_base_ff <= s1_base_in;
         s1_src_ff  <= req_source_pixel;
         s1_ext_ff  <= external_mode_ff;
      end
   end

   // stage 2: both terms in fixed point
   logic signed [TW-1:0]  s2_d1q_ff, s2_d1q_in;
   logic signed [TW-1:0]  s2_tq_ff, s2_tq_in;
   logic [PIXEL_BITS-1:0] s2_base_ff;
   logic [PIXEL_BITS-1:0] s2_src_ff;
   logic signed [TW-1:0]  gain_product;

   always_comb begin
      gain_product = TW'(s1_diff_ff) * TW'($signed({1'b0, strength_ff}));
      s2_d1q_in    = TW'(s1_d1_ff) <<< FRAC_BITS;
      s2_tq_in     = s1_ext_ff ? (TW'(s1_diff_ff) <<< FRAC_BITS) : gain_product;
   end

   always_ff @(posedge clock) begin
      if (load[1]) begin
         s2_d1q_ff  <= s2_d1q_in;
         s2_tq_ff   <= s2_tq_in;
         s2_base_ff <= s1_base_ff;
         s2_src_ff  <= s1_src_ff;
      end
   end

   // stage 3: pick the smaller magnitude, ties go to the second term
   logic signed [TW-1:0]  s3_daq_ff, s3_daq_in;
   logic                  s3_disagree_ff, s3_disagree_in;
   logic [PIXEL_BITS-1:0] s3_base_ff;
   logic [PIXEL_BITS-1:0] s3_src_ff;
   logic [TW-1:0]         d1_mag, t_mag;
   logic                  d1_neg, d1_pos, t_neg, t_pos;

   always_comb begin
      d1_neg = s2_d1q_ff[TW-1];
      t_neg  = s2_tq_ff[TW-1];
      d1_pos = !d1_neg && (s2_d1q_ff != '0);
      t_pos  = !t_neg && (s2_tq_ff != '0);
      d1_mag = d1_neg ? TW'(-s2_d1q_ff) : TW'(s2_d1q_ff);
      t_mag  = t_neg ? TW'(-s2_tq_ff) : TW'(s2_tq_ff);
      s3_daq_in      = (d1_mag < t_mag) ? s2_d1q_ff : s2_tq_ff;
      s3_disagree_in = (d1_neg && t_pos) || (d1_pos && t_neg);
   end

   always_ff @(posedge clock) begin
      if (load[2]) begin
         s3_daq_ff      <= s3_daq_in;
         s3_disagree_ff <= s3_disagree_in;
         s3_base_ff     <= s2_base_ff;
         s3_src_ff      <= s2_src_ff;
      end
   end

   // stage 4: scale or align to the same double fraction point
   logic signed [PW-1:0]  s4_prod_ff, s4_prod_in;
   logic [PIXEL_BITS-1:0] s4_base_ff;
   logic [PIXEL_BITS-1:0] s4_src_ff;

   always_comb begin
      if (s3_disagree_ff) begin
         s4_prod_in = PW'(s3_daq_ff) * PW'($signed({1'b0, scale_ff}));
      end else begin
         s4_prod_in = PW'(s3_daq_ff) <<< FRAC_BITS;
      end
   end

   always_ff @(posedge clock) begin
      if (load[3]) begin
         s4_prod_ff <= s4_prod_in;
         s4_base_ff <= s3_base_ff;
         s4_src_ff  <= s3_src_ff;
      end
   end

   // stage 5: truncate toward zero and add to the base
   logic signed [SW-1:0]  s5_sum_ff, s5_sum_in;
   logic [PIXEL_BITS-1:0] s5_src_ff;
   logic [PW-1:0]         biased;
   logic signed [AW-1:0]  correction;

   always_comb begin
      biased     = s4_prod_ff[PW-1] ? (PW'(s4_prod_ff) + ROUND_BIAS) : PW'(s4_prod_ff);
      correction = $signed(biased[PW-1:2*FRAC_BITS]);
      s5_sum_in  = SW'(correction) + SW'($signed({1'b0, s4_base_ff}));
   end

   always_ff @(posedge clock) begin
      if (load[4]) begin
         s5_sum_ff <= s5_sum_in;
         s5_src_ff <= s4_src_ff;
      end
   end

   // stage 6: clamp to source +/- amount, then to the pixel range
   logic [PIXEL_BITS-1:0] s6_pixel_ff, s6_pixel_in;
   logic [PIXEL_BITS-1:0] s6_src_ff;
   logic signed [SW-1:0]  band_lo, band_hi, clamped;

   always_comb begin
      band_lo = SW'($signed({1'b0, s5_src_ff})) - SW'($signed({1'b0, amount_ff}));
      band_hi = SW'($signed({1'b0, s5_src_ff})) + SW'($signed({1'b0, amount_ff}));
      priority if (s5_sum_ff < band_lo) begin
         clamped = band_lo;
      end else if (s5_sum_ff > band_hi) begin
         clamped = band_hi;
      end else begin
         clamped = s5_sum_ff;
      end
      priority if (clamped < 0) begin
         s6_pixel_in = '0;
      end else if (clamped > SW'($signed({1'b0, PIX_MAX}))) begin
         s6_pixel_in = PIX_MAX;
      end else begin
         s6_pixel_in = clamped[PIXEL_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (load[5]) begin
         s6_pixel_ff <= s6_pixel_in;
         s6_src_ff   <= s5_src_ff;
      end
   end

   assign rsp_result_pixel = s6_pixel_ff;

   // checks
   a_reset_empties: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("pipeline not empty after reset");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> valid_ff[0])
      else $error("accepted beat missing from first stage");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (valid_ff == {NST{1'b1}}) && rsp_stall)
      else $error("input stalled with room in the pipeline");

   a_within_band: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (({1'b0, rsp_result_pixel} + {1'b0, amount_ff}) >= {1'b0, s6_src_ff})
                 && ({1'b0, rsp_result_pixel} <= ({1'b0, s6_src_ff} + {1'b0, amount_ff})))
      else $error("result outside source +/- amount");

endmodule

@@ dv/crl_checker.sv @@
// beat monitor, pixel predictor and result scoreboard for the combing residue limiter
module crl_checker #(
   parameter int PIXEL_BITS = 8,
   parameter int FRAC_BITS  = 12
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_stall,
   input  logic [PIXEL_BITS-1:0]                req_source_pixel,
   input  logic [PIXEL_BITS-1:0]                req_small_blur,
   input  logic [PIXEL_BITS-1:0]                req_second_ref,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  logic [PIXEL_BITS-1:0]                rsp_result_pixel,
   input  logic                                 csr_write_enable,
   input  logic [crl_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [crl_pkg::CSR_DATA_BITS-1:0]    csr_write_data,
   output int                                   pixels_in_flight,
   output int                                   fail_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint PIXEL_MAX = (longint'(1) << PIXEL_BITS) - 1;
   localparam longint UNIT_Q    = longint'(1) << FRAC_BITS;
   localparam longint UNIT_QQ   = longint'(1) << (2 * FRAC_BITS);

   logic [PIXEL_BITS-1:0]          amount_q;
   logic [crl_pkg::COEF_BITS-1:0]  strength_q;
   logic [crl_pkg::COEF_BITS-1:0]  scale_q;
   logic                           external_q;

   logic [PIXEL_BITS-1:0] expected_pixels[$];

   function automatic logic [PIXEL_BITS-1:0] limit_pixel(input logic [PIXEL_BITS-1:0] src_px,
                                                         input logic [PIXEL_BITS-1:0] blur_px,
                                                         input logic [PIXEL_BITS-1:0] other_px);
      longint src, blur, other, gain, factor, amt;
      longint d1q, tq, mag_d1, mag_t, pick, corr, base, level;
      logic   opposite;
      src    = src_px;
      blur   = blur_px;
      other  = other_px;
      gain   = strength_q;
      factor = scale_q;
      amt    = amount_q;
      d1q = (src - blur) * UNIT_Q;
      if (external_q) begin
         tq   = (src - other) * UNIT_Q;
         base = other;
      end else begin
         tq   = (blur - other) * gain;
         base = blur;
      end
      mag_d1 = (d1q < 0) ? -d1q : d1q;
      mag_t  = (tq < 0) ? -tq : tq;
      // ties go to the second term
      pick = (mag_d1 < mag_t) ? d1q : tq;
      opposite = (d1q < 0 && tq > 0) || (d1q > 0 && tq < 0);
      // signed longint division truncates toward zero
      corr  = opposite ? (pick * factor) / UNIT_QQ : pick / UNIT_Q;
      level = base + corr;
      if (level < src - amt) level = src - amt;
      if (level > src + amt) level = src + amt;
      if (level < 0) level = 0;
      if (level > PIXEL_MAX) level = PIXEL_MAX;
      return level[PIXEL_BITS-1:0];
   endfunction

   always @(posedge clock) begin
      logic [PIXEL_BITS-1:0] want;
      if (reset) begin
         amount_q   = PIXEL_BITS'(PIXEL_MAX);
         strength_q = crl_pkg::STRENGTH_RESET;
         scale_q    = crl_pkg::SCALE_RESET;
         external_q = 1'b0;
         expected_pixels.delete();
         pixels_in_flight <= 0;
         fail_count       <= 0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               crl_pkg::CSR_AMOUNT:        amount_q   = csr_write_data[PIXEL_BITS-1:0];
               crl_pkg::CSR_STRENGTH:      strength_q = csr_write_data[crl_pkg::COEF_BITS-1:0];
               crl_pkg::CSR_SCALE:         scale_q    = csr_write_data[crl_pkg::COEF_BITS-1:0];
               crl_pkg::CSR_EXTERNAL_MODE: external_q = csr_write_data[0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               $error("result_pixel: expected none, actual %0d", rsp_result_pixel);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_result_pixel !== want) begin
                  $error("result_pixel: expected %0d, actual %0d", want, rsp_result_pixel);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && !req_stall)
            expected_pixels.push_back(limit_pixel(req_source_pixel, req_small_blur,
                                                  req_second_ref));
         pixels_in_flight <= expected_pixels.size();
      end
   end

endmodule

@@ dv/tb.sv @@
// stimulus, idling and verdict for the combing residue limiter
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PIXEL_BITS    = 8;
   localparam int FRAC_BITS     = 12;
   localparam int PIXEL_TOP     = (1 << PIXEL_BITS) - 1;
   localparam int RANDOM_PIXELS = 1950;
   localparam int CYCLE_LIMIT   = 400000;

   // idling styles
   localparam int STYLE_NONE   = 0;
   localparam int STYLE_HEAVY  = 1;
   localparam int STYLE_SPARSE = 2;

   logic                               clock            = 1'b0;
   logic                               reset            = 1'b1;
   logic                               req_valid        = 1'b0;
   logic                               req_stall;
   logic [PIXEL_BITS-1:0]              req_source_pixel = '0;
   logic [PIXEL_BITS-1:0]              req_small_blur   = '0;
   logic [PIXEL_BITS-1:0]              req_second_ref   = '0;
   logic                               rsp_valid;
   logic                               rsp_stall        = 1'b0;
   logic [PIXEL_BITS-1:0]              rsp_result_pixel;
   logic                               csr_write_enable = 1'b0;
   logic [crl_pkg::CSR_INDEX_BITS-1:0] csr_index        = '0;
   logic [crl_pkg::CSR_DATA_BITS-1:0]  csr_write_data   = '0;

   int pixels_in_flight;
   int fail_count;
   int send_style = STYLE_NONE;
   int sent_beats = 0;
   int cycle_count;

   combing_residue_limiter #(
      .PIXEL_BITS (PIXEL_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_source_pixel (req_source_pixel),
      .req_small_blur   (req_small_blur),
      .req_second_ref   (req_second_ref),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_pixel (rsp_result_pixel),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   crl_checker #(
      .PIXEL_BITS (PIXEL_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_source_pixel (req_source_pixel),
      .req_small_blur   (req_small_blur),
      .req_second_ref   (req_second_ref),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_pixel (rsp_result_pixel),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .pixels_in_flight (pixels_in_flight),
      .fail_count       (fail_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int draw_wait(input int style);
      case (style)
         STYLE_NONE:  return 0;
         STYLE_HEAVY: return $urandom_range(0, 19);
         default:     return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 19) : 0;
      endcase
   endfunction

   function automatic logic [PIXEL_BITS-1:0] nudge(input logic [PIXEL_BITS-1:0] v,
                                                   input int span);
      int r;
      r = int'(v) + int'($urandom_range(0, 2 * span)) - span;
      if (r < 0) r = 0;
      if (r > PIXEL_TOP) r = PIXEL_TOP;
      return r[PIXEL_BITS-1:0];
   endfunction

   function automatic logic [PIXEL_BITS-1:0] edge_or_any();
      case ($urandom_range(0, 2))
         0:       return '0;
         1:       return PIXEL_BITS'(PIXEL_TOP);
         default: return PIXEL_BITS'($urandom);
      endcase
   endfunction

   function automatic logic [crl_pkg::COEF_BITS-1:0] pick_coef();
      case ($urandom_range(0, 4))
         0:       return '0;
         1:       return '1;
         2:       return crl_pkg::COEF_BITS'(1 << FRAC_BITS);
         default: return crl_pkg::COEF_BITS'($urandom);
      endcase
   endfunction

   // leaves the write enable high so back-to-back writes need no toggle
   task automatic write_csr(input logic [crl_pkg::CSR_INDEX_BITS-1:0] idx,
                            input logic [crl_pkg::CSR_DATA_BITS-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
   endtask

   task automatic send_pixel(input logic [PIXEL_BITS-1:0] src,
                             input logic [PIXEL_BITS-1:0] blur,
                             input logic [PIXEL_BITS-1:0] other);
      int gap;
      gap = draw_wait(send_style);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_source_pixel <= src;
      req_small_blur   <= blur;
      req_second_ref   <= other;
      do @(posedge clock); while (req_stall);
      sent_beats++;
      if (sent_beats % 64 == 0) send_style = $urandom_range(STYLE_NONE, STYLE_SPARSE);
   endtask

   task automatic send_random_pixel();
      logic [PIXEL_BITS-1:0] src, blur, other;
      case ($urandom_range(0, 3))
         0: begin
            src   = PIXEL_BITS'($urandom);
            blur  = PIXEL_BITS'($urandom);
            other = PIXEL_BITS'($urandom);
         end
         1: begin
            src   = PIXEL_BITS'($urandom);
            blur  = nudge(src, 12);
            other = nudge(blur, 12);
         end
         2: begin
            src   = edge_or_any();
            blur  = edge_or_any();
            other = edge_or_any();
         end
         default: begin
            src   = PIXEL_BITS'($urandom);
            blur  = nudge(src, 60);
            other = nudge(src, 60);
         end
      endcase
      send_pixel(src, blur, other);
   endtask

   // wait until no pixel is left in flight, then keep idling before returning
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pixels_in_flight != 0);
      repeat (crl_pkg::NUM_STAGES + 2) @(posedge clock);
   endtask

   task automatic configure_random();
      logic [PIXEL_BITS-1:0] amt;
      case ($urandom_range(0, 4))
         0:       amt = '0;
         1:       amt = PIXEL_BITS'(1);
         2:       amt = PIXEL_BITS'(PIXEL_TOP);
         default: amt = PIXEL_BITS'($urandom);
      endcase
      if ($urandom_range(0, 3) != 0) write_csr(crl_pkg::CSR_AMOUNT, {8'($urandom), amt});
      if ($urandom_range(0, 3) != 0) write_csr(crl_pkg::CSR_STRENGTH, pick_coef());
      if ($urandom_range(0, 3) != 0) write_csr(crl_pkg::CSR_SCALE, pick_coef());
      if ($urandom_range(0, 2) != 0)
         write_csr(crl_pkg::CSR_EXTERNAL_MODE, {15'($urandom), 1'($urandom)});
      // indexes past the register list must leave every register alone
      if ($urandom_range(0, 4) == 0)
         write_csr(crl_pkg::CSR_EXTERNAL_MODE + 3'($urandom_range(1, 4)), 16'($urandom));
      csr_write_enable <= 1'b0;
   endtask

   // result side: stall drawn per beat, style redrawn every 64 beats
   initial begin
      int hold, rsp_style, taken;
      rsp_style = STYLE_NONE;
      taken     = 0;
      do @(posedge clock); while (reset);
      forever begin
         hold = draw_wait(rsp_style);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!rsp_valid);
         taken++;
         if (taken % 64 == 0) rsp_style = $urandom_range(STYLE_NONE, STYLE_SPARSE);
      end
   end

   initial begin
      for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clock);
      $display("FAILURE");
      $finish;
   end

   initial begin
      int chunk, done_random;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset settings, internal blur: extremes, zero terms, sign disagreement
      send_pixel(8'd0, 8'd0, 8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd255, 8'd0, 8'd0);
      send_pixel(8'd0, 8'd255, 8'd255);
      send_pixel(8'd255, 8'd0, 8'd255);
      send_pixel(8'd0, 8'd255, 8'd0);
      send_pixel(8'd128, 8'd128, 8'd0);
      send_pixel(8'd100, 8'd90, 8'd120);
      send_pixel(8'd90, 8'd100, 8'd100);
      wait_drained();

      // unity gain so equal magnitudes occur, full scale on disagreement
      write_csr(crl_pkg::CSR_AMOUNT, 16'hABFF);
      write_csr(crl_pkg::CSR_STRENGTH, 16'(1 << FRAC_BITS));
      write_csr(crl_pkg::CSR_SCALE, 16'hFFFF);
      csr_write_enable <= 1'b0;
      send_pixel(8'd150, 8'd100, 8'd50);
      send_pixel(8'd50, 8'd100, 8'd150);
      send_pixel(8'd150, 8'd100, 8'd150);
      send_pixel(8'd255, 8'd0, 8'd255);
      send_pixel(8'd0, 8'd255, 8'd0);
      wait_drained();

      // external clip with zero amount: output must follow the source
      write_csr(crl_pkg::CSR_EXTERNAL_MODE, 16'hFFFF);
      write_csr(crl_pkg::CSR_AMOUNT, 16'h5A00);
      csr_write_enable <= 1'b0;
      send_pixel(8'd200, 8'd100, 8'd50);
      send_pixel(8'd0, 8'd255, 8'd255);
      wait_drained();

      // external clip, amount of one, zero coefficients, stray index
      write_csr(crl_pkg::CSR_AMOUNT, 16'h0001);
      write_csr(crl_pkg::CSR_SCALE, 16'h0000);
      write_csr(crl_pkg::CSR_STRENGTH, 16'h0000);
      write_csr(crl_pkg::CSR_EXTERNAL_MODE + 3'd2, 16'hFFFF);
      csr_write_enable <= 1'b0;
      send_pixel(8'd255, 8'd0, 8'd0);
      send_pixel(8'd0, 8'd255, 8'd255);
      send_pixel(8'd10, 8'd20, 8'd5);
      send_pixel(8'd10, 8'd20, 8'd30);
      wait_drained();

      done_random = 0;
      while (done_random < RANDOM_PIXELS) begin
         configure_random();
         chunk = $urandom_range(60, 250);
         if (chunk > RANDOM_PIXELS - done_random) chunk = RANDOM_PIXELS - done_random;
         repeat (chunk) send_random_pixel();
         done_random += chunk;
         wait_drained();
      end

      repeat (crl_pkg::NUM_STAGES * 4) @(posedge clock);
      if (fail_count == 0 && pixels_in_flight == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
